// ===== src/vbi_pkg.sv =====
// ----------------------------------------------------------------------------
// vbi_pkg
// Shared types, codes and fixed-point helpers of the vertex body integrator.
// ----------------------------------------------------------------------------
package vbi_pkg;

    // operation codes carried in tuser
    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_FORCE   = 3'd1;
    localparam logic [2:0] OP_GRAVITY = 3'd2;
    localparam logic [2:0] OP_SCALE   = 3'd3;
    localparam logic [2:0] OP_STEP    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_VERTEX_COUNT = 3'd0;
    localparam logic [2:0] CFG_MASS         = 3'd1;
    localparam logic [2:0] CFG_DAMPING      = 3'd2;
    localparam logic [2:0] CFG_GRAVITY_X    = 3'd3;
    localparam logic [2:0] CFG_GRAVITY_Y    = 3'd4;
    localparam logic [2:0] CFG_GRAVITY_Z    = 3'd5;
    localparam logic [2:0] CFG_TIME_STEP    = 3'd6;

    localparam logic [6:0]  VCOUNT_RESET = 7'd1;
    localparam logic [30:0] MASS_RESET   = 31'd65536;
    localparam logic [16:0] DAMP_RESET   = 17'd65536;
    localparam logic [16:0] DT_RESET     = 17'd1092;

    // 0.9 in Q0.16
    localparam logic signed [32:0] FRICTION_Q16 = 33'sd58982;

    typedef enum logic [2:0] {
        MUL_DAMP,
        MUL_ACCEL,
        MUL_DELTA,
        MUL_FRIC,
        MUL_GRAV,
        MUL_SCALE
    } mul_sel_t;

    typedef struct packed {
        logic     item_load;
        logic     mem_load;
        logic     force_add;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     grav_scale;
        logic     grav_add;
        logic     div_start;
        logic     vel_damp;
        logic     vel_accel;
        logic     dlt_load;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     rd_en;
        logic     pos_add1;
        logic     pos_add2;
        logic     vel_fric;
        logic     scale_wr;
        logic     out_load;
    } vbi_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic cnt_last;
        logic div_busy;
        logic pos_neg;
        logic out_free;
    } vbi_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh000000007FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sh0000000080000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // floor of a product over 65536
    function automatic logic signed [48:0] shr16(input logic signed [64:0] p);
        return p[64:16];
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [48:0] b);
        logic signed [63:0] s;
        s = {{32{a[31]}}, a} + {{15{b[48]}}, b};
        return sat32(s);
    endfunction

endpackage

// ===== src/vertex_body_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// vertex_body_integrator_unit
// Vertex body integrator: a table of vertex positions moved by one shared
// velocity under an accumulated force, with ground contact at y = 0.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. A step's setup is bound by the bit-serial
// force/mass dividers, then each vertex passes through the vertex memory, with
// extra states for each vertex that bounces off the ground, and each vertex waits
// for the output beat before it to be taken. The last vertex may still wait
// in the output register while the next input beat is accepted.
module vertex_body_integrator_unit
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // vertex_index, value_x, value_y, value_z, pad
    input  logic [2:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,  // out_index, pos_x, pos_y, pos_z, pad
    output logic         m_tlast   // last
);
    import vbi_pkg::*;

    vbi_cmd_t cmd;
    vbi_sts_t sts;

    vbi_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    vbi_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== src/vbi_div.sv =====
// ----------------------------------------------------------------------------
// vbi_div
// Restoring divider, one quotient bit per cycle: (num * 65536) / den,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module vbi_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic        [30:0] den,
    output logic               busy,
    output logic signed [31:0] quo
);
    import vbi_pkg::*;

    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    logic        [5:0]  cnt_reg, cnt_next;
    logic        [47:0] dvd_reg, dvd_next;
    logic        [30:0] rem_reg, rem_next;
    logic        [30:0] den_reg, den_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] quo_reg, quo_next;
    logic        [31:0] mag;
    logic        [31:0] rem_sh;
    logic               ge;

    always_comb
    begin
        mag       = num[31] ? 32'(-num) : 32'(num);
        rem_sh    = {rem_reg, dvd_reg[47]};
        ge        = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        fin_next  = fin_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            fin_next  = 1'b0;
            cnt_next  = 6'd47;
            dvd_next  = {mag, 16'd0};
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[31];
        end
        else if (fin_reg)
        begin
            fin_next  = 1'b0;
            busy_next = 1'b0;
            if (neg_reg)
                quo_next = (dvd_reg > 48'h0000_8000_0000) ? 32'sh80000000
                                                          : 32'(-dvd_reg);
            else
                quo_next = (dvd_reg > 48'h0000_7FFF_FFFF) ? 32'sh7FFFFFFF
                                                          : dvd_reg[31:0];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 31'(rem_sh - {1'b0, den_reg}) : rem_sh[30:0];
            dvd_next = {dvd_reg[46:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
                fin_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ===== src/vbi_dp.sv =====
// ----------------------------------------------------------------------------
// vbi_dp
// Datapath: configuration registers, vertex memory, velocity and force
// registers, three multiplier lanes, dividers and the output register.
// ----------------------------------------------------------------------------
module vbi_dp
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [103:0]         s_tdata,
    input  vbi_pkg::vbi_cmd_t    cmd,
    output vbi_pkg::vbi_sts_t    sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [103:0]         m_tdata,
    output logic                 m_tlast
);
    import vbi_pkg::*;

    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam logic [6:0] MAX_V = 7'(MAX_VERTICES);

    // configuration
    logic        [6:0]  vcount_reg;
    logic        [30:0] mass_reg;
    logic        [16:0] damp_reg;
    logic signed [31:0] grav_reg [3];
    logic        [16:0] dt_reg;

    // item
    logic        [5:0]  vidx_reg;
    logic signed [31:0] val_reg [3];

    // state
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] frc_reg [3];
    logic signed [48:0] dlt_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [64:0] prod_reg [3];
    logic signed [56:0] gterm_reg [3];
    logic        [CNT_W-1:0] cnt_reg;

    logic        [95:0] mem [MAX_VERTICES];
    logic        [95:0] rdata_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic        [95:0] mem_wd;

    logic               out_valid_reg;
    logic        [5:0]  out_index_reg;
    logic signed [31:0] out_pos_reg [3];
    logic               out_last_reg;

    logic signed [31:0] mul_a [3];
    logic signed [32:0] mul_b [3];
    logic        [CNT_W-1:0] n_used;
    logic        [30:0] mass_eff;
    logic               cnt_last;
    logic               load_ok;
    logic        [2:0]  div_busy;
    logic signed [31:0] acc [3];
    logic signed [31:0] scale_y;

    always_comb
    begin
        n_used   = (vcount_reg > MAX_V) ? CNT_W'(MAX_VERTICES) : CNT_W'(vcount_reg);
        mass_eff = (mass_reg == '0) ? 31'd1 : mass_reg;
        cnt_last = ({1'b0, cnt_reg} + 1'b1) == {1'b0, n_used};
        load_ok  = {1'b0, vidx_reg} < MAX_V;
        scale_y  = add_sat(32'sd0, shr16(prod_reg[1]));
    end

    // multiplier operand selection
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            unique case (cmd.mul_sel)
                MUL_DAMP:
                begin
                    mul_a[l] = vel_reg[l];
                    mul_b[l] = $signed({16'd0, damp_reg});
                end
                MUL_ACCEL:
                begin
                    mul_a[l] = acc[l];
                    mul_b[l] = $signed({16'd0, dt_reg});
                end
                MUL_DELTA:
                begin
                    mul_a[l] = vel_reg[l];
                    mul_b[l] = $signed({16'd0, dt_reg});
                end
                MUL_FRIC:
                begin
                    mul_a[l] = vel_reg[l];
                    mul_b[l] = FRICTION_Q16;
                end
                MUL_GRAV:
                begin
                    mul_a[l] = grav_reg[l];
                    mul_b[l] = $signed({2'd0, mass_reg});
                end
                MUL_SCALE:
                begin
                    mul_a[l] = rdata_reg[63:32];
                    mul_b[l] = {val_reg[0][31], val_reg[0]};
                end
                default:
                begin
                    mul_a[l] = vel_reg[l];
                    mul_b[l] = FRICTION_Q16;
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            vbi_div u_div
            (
                .clk   (clk),
                .rst_n (rst_n),
                .start (cmd.div_start),
                .num   (frc_reg[g]),
                .den   (mass_eff),
                .busy  (div_busy[g]),
                .quo   (acc[g])
            );
        end
    endgenerate

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg  <= VCOUNT_RESET;
            mass_reg    <= MASS_RESET;
            damp_reg    <= DAMP_RESET;
            grav_reg[0] <= '0;
            grav_reg[1] <= '0;
            grav_reg[2] <= '0;
            dt_reg      <= DT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT: vcount_reg  <= cfg_data[6:0];
                CFG_MASS:         mass_reg    <= cfg_data[30:0];
                CFG_DAMPING:      damp_reg    <= cfg_data[16:0];
                CFG_GRAVITY_X:    grav_reg[0] <= cfg_data;
                CFG_GRAVITY_Y:    grav_reg[1] <= cfg_data;
                CFG_GRAVITY_Z:    grav_reg[2] <= cfg_data;
                CFG_TIME_STEP:    dt_reg      <= cfg_data[16:0];
                default:          ;
            endcase
        end
    end

    // velocity, force and loop counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < 3; l++)
            begin
                vel_reg[l] <= '0;
                frc_reg[l] <= '0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (cmd.force_add)
                    frc_reg[l] <= add_sat(frc_reg[l], 49'(val_reg[l]));
                else if (cmd.grav_add)
                    frc_reg[l] <= sat32({{32{frc_reg[l][31]}}, frc_reg[l]}
                                        + {{7{gterm_reg[l][56]}}, gterm_reg[l]});
                else if (cmd.vel_accel)
                    frc_reg[l] <= '0;

                if (cmd.vel_damp)
                    vel_reg[l] <= add_sat(32'sd0, shr16(prod_reg[l]));
                else if (cmd.vel_accel)
                    vel_reg[l] <= add_sat(vel_reg[l], shr16(prod_reg[l]));
                else if (cmd.vel_fric)
                begin
                    if (l == 1)
                        vel_reg[l] <= add_sat(32'sd0, -shr16(prod_reg[l]));
                    else
                        vel_reg[l] <= add_sat(32'sd0, shr16(prod_reg[l]));
                end
            end
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            vidx_reg   <= s_tdata[5:0];
            val_reg[0] <= s_tdata[37:6];
            val_reg[1] <= s_tdata[69:38];
            val_reg[2] <= s_tdata[101:70];
        end
        for (int l = 0; l < 3; l++)
        begin
            if (cmd.mul_en)
                prod_reg[l] <= mul_a[l] * mul_b[l];
            if (cmd.grav_scale)
                gterm_reg[l] <= shr16(prod_reg[l]) * $signed({1'b0, 7'(n_used)});
            if (cmd.dlt_load)
                dlt_reg[l] <= shr16(prod_reg[l]);
            if (cmd.pos_add1)
                pos_reg[l] <= add_sat(rdata_reg[l*32 +: 32], dlt_reg[l]);
            else if (cmd.pos_add2 && pos_reg[1][31])
                pos_reg[l] <= add_sat(pos_reg[l], dlt_reg[l]);
            else if (cmd.vel_fric && l == 1)
                pos_reg[l] <= '0;
        end
    end

    // vertex memory
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cnt_reg[IDX_W-1:0];
        mem_wd = {pos_reg[2], pos_reg[1], pos_reg[0]};
        if (cmd.mem_load)
        begin
            mem_we = load_ok;
            mem_wa = vidx_reg[IDX_W-1:0];
            mem_wd = {val_reg[2], val_reg[1], val_reg[0]};
        end
        else if (cmd.scale_wr)
        begin
            mem_we = 1'b1;
            mem_wd = {rdata_reg[95:64], scale_y, rdata_reg[31:0]};
        end
        else if (cmd.out_load)
            mem_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (cmd.rd_en)
            rdata_reg <= mem[cnt_reg[IDX_W-1:0]];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_index_reg  <= 6'(cnt_reg);
            out_pos_reg[0] <= pos_reg[0];
            out_pos_reg[1] <= pos_reg[1];
            out_pos_reg[2] <= pos_reg[2];
            out_last_reg   <= cnt_last;
        end
    end

    assign sts.n_zero   = (n_used == '0);
    assign sts.cnt_last = cnt_last;
    assign sts.div_busy = |div_busy;
    assign sts.pos_neg  = pos_reg[1][31];
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_pos_reg[2], out_pos_reg[1], out_pos_reg[0],
                       out_index_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/vbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// vbi_ctrl
// Sequencer: decodes each operation and steps the datapath through it.
// ----------------------------------------------------------------------------
module vbi_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2:0]        s_tuser,
    input  vbi_pkg::vbi_sts_t sts,
    output vbi_pkg::vbi_cmd_t cmd
);
    import vbi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_FORCE,
        S_GRAV_MUL,
        S_GRAV_N,
        S_GRAV_ADD,
        S_SC_RD,
        S_SC_MUL,
        S_SC_WR,
        S_DAMP,
        S_DAMP_WB,
        S_DIV,
        S_ACC_MUL,
        S_ACC_WB,
        S_DLT_MUL,
        S_DLT_WB,
        S_V_RD,
        S_V_ADD1,
        S_V_ADD2,
        S_V_CHK,
        S_V_FRW,
        S_V_DMUL,
        S_V_DWB,
        S_V_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.mul_sel = MUL_DAMP;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.item_load = 1'b1;
                    cmd.cnt_clr   = 1'b1;
                    unique case (s_tuser)
                        OP_LOAD:    state_next = S_LOAD;
                        OP_FORCE:   state_next = S_FORCE;
                        OP_GRAVITY: state_next = S_GRAV_MUL;
                        OP_SCALE:   state_next = sts.n_zero ? S_IDLE : S_SC_RD;
                        OP_STEP:    state_next = S_DAMP;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.mem_load = 1'b1;
                state_next   = S_IDLE;
            end
            S_FORCE:
            begin
                cmd.force_add = 1'b1;
                state_next    = S_IDLE;
            end
            S_GRAV_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GRAV;
                state_next  = S_GRAV_N;
            end
            S_GRAV_N:
            begin
                cmd.grav_scale = 1'b1;
                state_next     = S_GRAV_ADD;
            end
            S_GRAV_ADD:
            begin
                cmd.grav_add = 1'b1;
                state_next   = S_IDLE;
            end
            S_SC_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SC_MUL;
            end
            S_SC_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SCALE;
                state_next  = S_SC_WR;
            end
            S_SC_WR:
            begin
                cmd.scale_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
                state_next   = sts.cnt_last ? S_IDLE : S_SC_RD;
            end
            S_DAMP:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_DAMP;
                cmd.div_start = 1'b1;
                state_next    = S_DAMP_WB;
            end
            S_DAMP_WB:
            begin
                cmd.vel_damp = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                    state_next = S_ACC_MUL;
            end
            S_ACC_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ACCEL;
                state_next  = S_ACC_WB;
            end
            S_ACC_WB:
            begin
                cmd.vel_accel = 1'b1;
                state_next    = S_DLT_MUL;
            end
            S_DLT_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DELTA;
                state_next  = S_DLT_WB;
            end
            S_DLT_WB:
            begin
                cmd.dlt_load = 1'b1;
                state_next   = sts.n_zero ? S_IDLE : S_V_RD;
            end
            S_V_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_V_ADD1;
            end
            S_V_ADD1:
            begin
                cmd.pos_add1 = 1'b1;
                state_next   = S_V_ADD2;
            end
            S_V_ADD2:
            begin
                cmd.pos_add2 = 1'b1;
                state_next   = S_V_CHK;
            end
            S_V_CHK:
            begin
                // still below ground after the second move: bounce
                if (sts.pos_neg)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_FRIC;
                    state_next  = S_V_FRW;
                end
                else
                    state_next = S_V_OUT;
            end
            S_V_FRW:
            begin
                cmd.vel_fric = 1'b1;
                state_next   = S_V_DMUL;
            end
            S_V_DMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DELTA;
                state_next  = S_V_DWB;
            end
            S_V_DWB:
            begin
                cmd.dlt_load = 1'b1;
                state_next   = S_V_OUT;
            end
            S_V_OUT:
            begin
                // hold until the output register frees up
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    state_next   = sts.cnt_last ? S_IDLE : S_V_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule
